### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_P(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_P(name, clk, rstn, prop)
`define ASSERT_NEVER(name, clk, rstn, expr)

`endif

`endif

### rtl/core/lag_pkg.sv
// ----------------------------------------------------------------------------
// lag_pkg
// shared constants and types of the toroidal life grid core
// ----------------------------------------------------------------------------
`default_nettype none

package lag_pkg;

  // grid storage size
  localparam int unsigned MaxRows = 64;
  localparam int unsigned MaxCols = 64;
  localparam int unsigned RowW    = $clog2(MaxRows);
  localparam int unsigned ColW    = $clog2(MaxCols);

  // configuration port
  localparam int unsigned SizeW    = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] CfgGridRows = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGridCols = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRunning  = 2'd2;

  // stream payload
  localparam int unsigned RowFieldW = 6;
  localparam int unsigned ColFieldW = 6;
  localparam int unsigned CountW    = 32;
  localparam int unsigned SDataW    = 48;
  localparam int unsigned MDataW    = 40;
  localparam int unsigned SUserW    = 2;
  localparam int unsigned MUserW    = 2;

  // life rule
  localparam logic [3:0] SurviveMin = 4'd2;
  localparam logic [3:0] SurviveMax = 4'd3;
  localparam logic [3:0] BirthCount = 4'd3;

  typedef logic [MaxCols-1:0] row_t;

  typedef enum logic [1:0] {
    ActWrite = 2'd0,
    ActRead  = 2'd1,
    ActStep  = 2'd2,
    ActLoad  = 2'd3
  } action_e;

endpackage

`default_nettype wire

### rtl/core/life_automaton_grid_step_core.sv
// ----------------------------------------------------------------------------
// life_automaton_grid_step_core
// toroidal game of life grid with cell access and sequenced generation step
// ----------------------------------------------------------------------------
// load, stopped step and bad coordinate answer straight from idle; cell write/read passes through StCell
// generation step: copy every row to the snapshot, then per row load three rows, evaluate the cells and write back;
//   one cell per cycle through the shared rule unit, plus row loads over one read port
// one item at a time; ready again once back in idle with the output register free or being taken
// reset: grid reads all dead at once through per-row valid flags, counter zero,
//   size 64 x 64, stopped
`default_nettype none

`include "assert_macros.svh"

module life_automaton_grid_step_core
  import lag_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // row [5:0], col [11:6], cell_value [12], count_value [44:13], zero [47:45]
  input  logic [SDataW-1:0]   s_axis_tdata_i,
  // action [1:0]
  input  logic [SUserW-1:0]   s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // cell_state [0], generation [32:1], zero [39:33]
  output logic [MDataW-1:0]   m_axis_tdata_o,
  // stepped [0], bad_coord [1]
  output logic [MUserW-1:0]   m_axis_tuser_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    StIdle,
    StCell,
    StCopyRd,
    StCopyWr,
    StLdPrev,
    StLdMid,
    StLdNext,
    StLdLatch,
    StCells,
    StWrBack
  } state_e;

  state_e state_q;

  // configuration
  logic [SizeW-1:0] rows_q;
  logic [SizeW-1:0] cols_q;
  logic             run_q;
  logic [SizeW-1:0] rows_eff;
  logic [SizeW-1:0] cols_eff;
  logic [SizeW-1:0] rows_m1;
  logic [SizeW-1:0] cols_m1;
  logic [RowW-1:0]  last_row;
  logic [ColW-1:0]  last_col;

  // input fields
  action_e              s_action;
  logic [RowFieldW-1:0] s_row;
  logic [ColFieldW-1:0] s_col;
  logic                 s_val;
  logic [CountW-1:0]    s_count;
  logic                 s_acc;
  logic                 in_bad;

  // control registers
  logic [RowW-1:0]   row_q;
  logic [ColW-1:0]   col_q;
  logic [CountW-1:0] gen_q;
  logic              out_valid_q;
  logic              out_cell_q;
  logic [CountW-1:0] out_gen_q;
  logic              out_step_q;
  logic              out_bad_q;
  logic              out_load;
  logic [MaxRows-1:0] row_vld_q;

  // datapath registers
  action_e act_q;
  logic    val_q;
  row_t    above_q;
  row_t    mid_q;
  row_t    below_q;
  row_t    nrow_q;

  // memories
  row_t            live_mem [MaxRows];
  row_t            snap_mem [MaxRows];
  row_t            live_rd_q;
  logic            live_vld_rd_q;
  row_t            snap_rd_q;
  logic [RowW-1:0] live_raddr;
  logic            live_we;
  row_t            live_wdata;
  row_t            live_row;
  row_t            cell_wrow;
  logic [RowW-1:0] snap_raddr;
  logic [RowW-1:0] row_prev;
  logic [RowW-1:0] row_next;
  logic            cell_alive;

  assign s_action = action_e'(s_axis_tuser_i[1:0]);
  assign s_row    = s_axis_tdata_i[5:0];
  assign s_col    = s_axis_tdata_i[11:6];
  assign s_val    = s_axis_tdata_i[12];
  assign s_count  = s_axis_tdata_i[44:13];

  // out-of-range sizes act as the nearest legal size
  always_comb begin
    if (rows_q == '0) begin
      rows_eff = SizeW'(1);
    end else if (rows_q > SizeW'(MaxRows)) begin
      rows_eff = SizeW'(MaxRows);
    end else begin
      rows_eff = rows_q;
    end
    if (cols_q == '0) begin
      cols_eff = SizeW'(1);
    end else if (cols_q > SizeW'(MaxCols)) begin
      cols_eff = SizeW'(MaxCols);
    end else begin
      cols_eff = cols_q;
    end
  end

  assign rows_m1  = rows_eff - SizeW'(1);
  assign cols_m1  = cols_eff - SizeW'(1);
  assign last_row = rows_m1[RowW-1:0];
  assign last_col = cols_m1[ColW-1:0];

  assign row_prev = (row_q == '0) ? last_row : row_q - RowW'(1);
  assign row_next = (row_q == last_row) ? '0 : row_q + RowW'(1);

  assign in_bad = (SizeW'(s_row) >= rows_eff) || (SizeW'(s_col) >= cols_eff);

  assign s_axis_tready_o = (state_q == StIdle) && (!out_valid_q || m_axis_tready_i);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  // live grid access; a row never written reads as all dead
  assign live_raddr = (state_q == StIdle) ? s_row[RowW-1:0] : row_q;
  assign live_row   = live_vld_rd_q ? live_rd_q : '0;

  always_comb begin
    cell_wrow        = live_row;
    cell_wrow[col_q] = val_q;
  end

  always_comb begin
    live_we    = 1'b0;
    live_wdata = nrow_q;
    case (state_q)
      StCell: begin
        live_we    = (act_q == ActWrite);
        live_wdata = cell_wrow;
      end
      StWrBack: begin
        live_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (state_q)
      StLdPrev: snap_raddr = row_prev;
      StLdNext: snap_raddr = row_next;
      default:  snap_raddr = row_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    live_rd_q <= live_mem[live_raddr];
    if (live_we) begin
      live_mem[row_q] <= live_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_rd_q <= snap_mem[snap_raddr];
    if (state_q == StCopyWr) begin
      snap_mem[row_q] <= live_row;
    end
  end

  lag_cell_unit u_cell (
    .above_i   (above_q),
    .mid_i     (mid_q),
    .below_i   (below_q),
    .col_i     (col_q),
    .last_col_i(last_col),
    .alive_o   (cell_alive)
  );

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      act_q <= s_action;
      val_q <= s_val;
    end
    case (state_q)
      StLdMid:  above_q <= snap_rd_q;
      StLdNext: mid_q   <= snap_rd_q;
      StLdLatch: begin
        below_q <= snap_rd_q;
        // columns outside the area in use keep their contents
        nrow_q  <= mid_q;
      end
      StCells:  nrow_q[col_q] <= cell_alive;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      rows_q        <= SizeW'(MaxRows);
      cols_q        <= SizeW'(MaxCols);
      run_q         <= 1'b0;
      row_q         <= '0;
      col_q         <= '0;
      gen_q         <= '0;
      out_valid_q   <= 1'b0;
      out_cell_q    <= 1'b0;
      out_gen_q     <= '0;
      out_step_q    <= 1'b0;
      out_bad_q     <= 1'b0;
      row_vld_q     <= '0;
      live_vld_rd_q <= 1'b0;
    end else begin
      live_vld_rd_q <= row_vld_q[live_raddr];
      if (live_we) begin
        row_vld_q[row_q] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgGridRows: rows_q <= cfg_wdata_i;
          CfgGridCols: cols_q <= cfg_wdata_i;
          CfgRunning:  run_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (s_acc) begin
            case (s_action)
              ActWrite, ActRead: begin
                if (in_bad) begin
                  out_valid_q <= 1'b1;
                  out_cell_q  <= 1'b0;
                  out_gen_q   <= gen_q;
                  out_step_q  <= 1'b0;
                  out_bad_q   <= 1'b1;
                end else begin
                  row_q   <= s_row[RowW-1:0];
                  col_q   <= s_col[ColW-1:0];
                  state_q <= StCell;
                end
              end
              ActStep: begin
                if (run_q) begin
                  row_q   <= '0;
                  state_q <= StCopyRd;
                end else begin
                  out_valid_q <= 1'b1;
                  out_cell_q  <= 1'b0;
                  out_gen_q   <= gen_q;
                  out_step_q  <= 1'b0;
                  out_bad_q   <= 1'b0;
                end
              end
              default: begin
                gen_q       <= s_count;
                out_valid_q <= 1'b1;
                out_cell_q  <= 1'b0;
                out_gen_q   <= s_count;
                out_step_q  <= 1'b0;
                out_bad_q   <= 1'b0;
              end
            endcase
          end
        end
        StCell: begin
          out_valid_q <= 1'b1;
          out_cell_q  <= (act_q == ActWrite) ? val_q : live_row[col_q];
          out_gen_q   <= gen_q;
          out_step_q  <= 1'b0;
          out_bad_q   <= 1'b0;
          state_q     <= StIdle;
        end
        StCopyRd: state_q <= StCopyWr;
        StCopyWr: begin
          if (row_q == last_row) begin
            row_q   <= '0;
            state_q <= StLdPrev;
          end else begin
            row_q   <= row_q + RowW'(1);
            state_q <= StCopyRd;
          end
        end
        StLdPrev: state_q <= StLdMid;
        StLdMid:  state_q <= StLdNext;
        StLdNext: state_q <= StLdLatch;
        StLdLatch: begin
          col_q   <= '0;
          state_q <= StCells;
        end
        StCells: begin
          if (col_q == last_col) begin
            state_q <= StWrBack;
          end else begin
            col_q <= col_q + ColW'(1);
          end
        end
        StWrBack: begin
          if (row_q == last_row) begin
            gen_q       <= gen_q + CountW'(1);
            out_valid_q <= 1'b1;
            out_cell_q  <= 1'b0;
            out_gen_q   <= gen_q + CountW'(1);
            out_step_q  <= 1'b1;
            out_bad_q   <= 1'b0;
            state_q     <= StIdle;
          end else begin
            row_q   <= row_q + RowW'(1);
            state_q <= StLdPrev;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_load = (s_acc && (state_q == StIdle) && ((s_action == ActLoad) ||
                    ((s_action == ActStep) && !run_q) ||
                    (((s_action == ActWrite) || (s_action == ActRead)) && in_bad))) ||
                    (state_q == StCell) ||
                    ((state_q == StWrBack) && (row_q == last_row));

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(MDataW - CountW - 1)'(0), out_gen_q, out_cell_q};
  assign m_axis_tuser_o  = {out_bad_q, out_step_q};

  `ASSERT_NEVER(a_out_overrun, clk_i, rst_ni, out_load && out_valid_q && !m_axis_tready_i)
  `ASSERT_P(a_step_counts, clk_i, rst_ni, ((state_q == StWrBack) && (row_q == last_row)) |=> (gen_q == $past(gen_q) + CountW'(1)))
  `ASSERT_P(a_row_marked, clk_i, rst_ni, live_we |=> row_vld_q[$past(row_q)])
  `ASSERT_P(a_cell_from_accept, clk_i, rst_ni, (state_q == StCell) |-> $past(s_acc))

endmodule

`default_nettype wire

### rtl/core/lag_cell_unit.sv
// ----------------------------------------------------------------------------
// lag_cell_unit
// shared neighbor count and B3/S23 rule for one cell of a buffered row
// ----------------------------------------------------------------------------
`default_nettype none

module lag_cell_unit
  import lag_pkg::*;
(
  input  row_t            above_i,
  input  row_t            mid_i,
  input  row_t            below_i,
  input  logic [ColW-1:0] col_i,
  input  logic [ColW-1:0] last_col_i,
  output logic            alive_o
);

  logic [ColW-1:0] cp;
  logic [ColW-1:0] cn;
  logic [3:0]      n;

  // wrap at the edges of the area in use
  assign cp = (col_i == '0) ? last_col_i : col_i - ColW'(1);
  assign cn = (col_i == last_col_i) ? '0 : col_i + ColW'(1);

  assign n = {3'b000, above_i[cp]} + {3'b000, above_i[col_i]} + {3'b000, above_i[cn]}
           + {3'b000, mid_i[cp]}                              + {3'b000, mid_i[cn]}
           + {3'b000, below_i[cp]} + {3'b000, below_i[col_i]} + {3'b000, below_i[cn]};

  always_comb begin
    if (mid_i[col_i]) begin
      alive_o = (n >= SurviveMin) && (n <= SurviveMax);
    end else begin
      alive_o = (n == BirthCount);
    end
  end

endmodule

`default_nettype wire
